@@ rtl/core/feistel_sha256_block_decrypt_macros.svh @@
// ----------------------------------------------------------------------------
// Feistel SHA-256 block decrypt assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FEISTEL_SHA256_BLOCK_DECRYPT_MACROS_SVH
`define FEISTEL_SHA256_BLOCK_DECRYPT_MACROS_SVH

// same-cycle implication
`define FSB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/fsb_pkg.sv @@
// ----------------------------------------------------------------------------
// Feistel SHA-256 block decrypt package
// SHA-256 constants, pipeline stage types and round helper functions.
// ----------------------------------------------------------------------------
package fsb_pkg;

  localparam int SHA_STEPS = 64;

  typedef logic [31:0] word_t;
  typedef logic [255:0] half_blk_t;

  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic             valid;
    half_blk_t        lh;
    half_blk_t        rh;
    logic [7:0][31:0] vars;
    logic [15:0][31:0] win;
  } stage_t;

  typedef struct packed {
    logic      valid;
    half_blk_t lh;
    half_blk_t rh;
  } half_t;

  localparam word_t SHA_K [SHA_STEPS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0][31:0] SHA_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // message length in bits, padding marker word
  localparam word_t MSG_LEN_WORD = 32'h0000_0150;
  localparam word_t PAD_WORD     = 32'h0000_8000;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [15:0][31:0] build_win(input half_blk_t rh, input logic [15:0] seg);
    logic [15:0][31:0] w;
    w = '0;
    for (int j = 0; j < 8; j++) begin
      w[j] = rh[255 - 32*j -: 32];
    end
    w[8]  = {seg, 16'h0000};
    w[10] = PAD_WORD;
    w[15] = MSG_LEN_WORD;
    build_win = w;
  endfunction

endpackage

@@ rtl/core/fsb_blk_if.sv @@
// ----------------------------------------------------------------------------
// Block channel interface
// Valid/ready channel carrying one 64-byte block as eight 64-bit words.
// ----------------------------------------------------------------------------
interface fsb_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_word_0;
  logic [63:0] block_word_1;
  logic [63:0] block_word_2;
  logic [63:0] block_word_3;
  logic [63:0] block_word_4;
  logic [63:0] block_word_5;
  logic [63:0] block_word_6;
  logic [63:0] block_word_7;

  modport source (output valid, block_word_0, block_word_1, block_word_2, block_word_3,
                  block_word_4, block_word_5, block_word_6, block_word_7, input ready);
  modport sink (input valid, block_word_0, block_word_1, block_word_2, block_word_3,
                block_word_4, block_word_5, block_word_6, block_word_7, output ready);
endinterface

@@ rtl/core/fsb_plain_if.sv @@
// ----------------------------------------------------------------------------
// Plaintext channel interface
// Valid/ready channel carrying one 64-byte plaintext as eight 64-bit words.
// ----------------------------------------------------------------------------
interface fsb_plain_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_word_0;
  logic [63:0] plain_word_1;
  logic [63:0] plain_word_2;
  logic [63:0] plain_word_3;
  logic [63:0] plain_word_4;
  logic [63:0] plain_word_5;
  logic [63:0] plain_word_6;
  logic [63:0] plain_word_7;

  modport source (output valid, plain_word_0, plain_word_1, plain_word_2, plain_word_3,
                  plain_word_4, plain_word_5, plain_word_6, plain_word_7, input ready);
  modport sink (input valid, plain_word_0, plain_word_1, plain_word_2, plain_word_3,
                plain_word_4, plain_word_5, plain_word_6, plain_word_7, output ready);
endinterface

@@ rtl/core/fsb_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration write interface
// Valid/ready write channel with register index and 64-bit data.
// ----------------------------------------------------------------------------
interface fsb_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/feistel_sha256_block_decrypt.sv @@
// Throughput: one block per cycle while the output is not stalled; each
// Feistel round is 64 compression stages plus one combine stage, all
// advancing together under one output stall.
// Reset: rst_n synchronous active low clears all stage valid bits and both key
// registers; the configuration port is always ready.
// ----------------------------------------------------------------------------
// Feistel SHA-256 block decrypt
// Fully pipelined Feistel decryptor, five rounds by default, with SHA-256 round function.
// ----------------------------------------------------------------------------
module feistel_sha256_block_decrypt #(
  parameter int ROUND_COUNT = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  fsb_blk_if.sink     in_blk,
  fsb_plain_if.source out_plain,
  fsb_cfg_if.sink     cfg_wr
);

  `include "feistel_sha256_block_decrypt_macros.svh"

  localparam int STAGES = fsb_pkg::SHA_STEPS + 1;

  logic [63:0] key_low_r;
  logic [15:0] key_high_r;
  logic        en;

  fsb_pkg::stage_t chain [ROUND_COUNT][STAGES];
  fsb_pkg::half_t  fin_r [ROUND_COUNT];

  assign en            = !fin_r[ROUND_COUNT-1].valid || out_plain.ready;
  assign in_blk.ready  = en;
  assign cfg_wr.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        fsb_pkg::REG_KEY_LOW:  key_low_r  <= cfg_wr.data;
        fsb_pkg::REG_KEY_HIGH: key_high_r <= cfg_wr.data[15:0];
        default: ;
      endcase
    end
  end

  genvar r, s;
  generate
    for (r = 0; r < ROUND_COUNT; r++) begin : g_round
      localparam int SEG = ROUND_COUNT - 1 - r;
      logic [79:0]               key_all;
      logic [15:0]               seg_bits;
      fsb_pkg::half_t            rin;
      logic [255:0]              digest;
      fsb_pkg::stage_t           last;

      assign key_all  = {key_low_r, key_high_r};
      assign seg_bits = key_all[79 - 16*SEG -: 16];

      if (r == 0) begin : g_first
        assign rin.valid = in_blk.valid;
        assign rin.lh = {in_blk.block_word_4, in_blk.block_word_5,
                         in_blk.block_word_6, in_blk.block_word_7};
        assign rin.rh = {in_blk.block_word_0, in_blk.block_word_1,
                         in_blk.block_word_2, in_blk.block_word_3};
      end else begin : g_next
        assign rin = fin_r[r-1];
      end

      always_comb begin
        chain[r][0].valid = rin.valid;
        chain[r][0].lh    = rin.lh;
        chain[r][0].rh    = rin.rh;
        chain[r][0].vars  = fsb_pkg::SHA_INIT;
        chain[r][0].win   = fsb_pkg::build_win(rin.rh, seg_bits);
      end

      for (s = 0; s < fsb_pkg::SHA_STEPS; s++) begin : g_step
        fsb_sha_step #(.STEP(s)) u_step (
          .clk  (clk),
          .rst_n(rst_n),
          .en   (en),
          .st_i (chain[r][s]),
          .st_o (chain[r][s+1])
        );
      end

      assign last = chain[r][STAGES-1];

      always_comb begin
        for (int j = 0; j < 8; j++) begin
          digest[255 - 32*j -: 32] = fsb_pkg::SHA_INIT[j] + last.vars[j];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          fin_r[r].valid <= 1'b0;
        end else if (en) begin
          fin_r[r].valid <= last.valid;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          fin_r[r].lh <= last.rh;
          fin_r[r].rh <= last.lh ^ digest;
        end
      end
    end
  endgenerate

  assign out_plain.valid        = fin_r[ROUND_COUNT-1].valid;
  assign out_plain.plain_word_0 = fin_r[ROUND_COUNT-1].rh[255:192];
  assign out_plain.plain_word_1 = fin_r[ROUND_COUNT-1].rh[191:128];
  assign out_plain.plain_word_2 = fin_r[ROUND_COUNT-1].rh[127:64];
  assign out_plain.plain_word_3 = fin_r[ROUND_COUNT-1].rh[63:0];
  assign out_plain.plain_word_4 = fin_r[ROUND_COUNT-1].lh[255:192];
  assign out_plain.plain_word_5 = fin_r[ROUND_COUNT-1].lh[191:128];
  assign out_plain.plain_word_6 = fin_r[ROUND_COUNT-1].lh[127:64];
  assign out_plain.plain_word_7 = fin_r[ROUND_COUNT-1].lh[63:0];

  `FSB_ASSERT_NEXT(a_enter, in_blk.valid && in_blk.ready, chain[0][1].valid, "request lost at entry")
  `FSB_ASSERT_NEXT(a_hold_mid, !en, $stable(chain[0][32].valid), "stage moved during stall")
  `FSB_ASSERT_NEXT(a_hold_out, !en, $stable(fin_r[ROUND_COUNT-1].rh), "result changed during stall")
  `FSB_ASSERT_NOW(a_ready, !fin_r[ROUND_COUNT-1].valid, in_blk.ready, "input blocked with empty output")

endmodule

@@ rtl/core/fsb_sha_step.sv @@
// ----------------------------------------------------------------------------
// SHA-256 compression step stage
// One registered compression round with rolling message schedule window.
// ----------------------------------------------------------------------------
module fsb_sha_step #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  fsb_pkg::stage_t st_i,
  output fsb_pkg::stage_t st_o
);

  fsb_pkg::stage_t st_r;
  fsb_pkg::stage_t st_nxt;
  fsb_pkg::word_t  wcur;
  fsb_pkg::word_t  t1;
  fsb_pkg::word_t  t2;
  fsb_pkg::word_t  ch;
  fsb_pkg::word_t  maj;

  always_comb begin
    if (STEP < 16) begin
      wcur = st_i.win[0];
    end else begin
      wcur = st_i.win[0] + fsb_pkg::ssig0(st_i.win[1]) + st_i.win[9] +
             fsb_pkg::ssig1(st_i.win[14]);
    end
    ch  = (st_i.vars[4] & st_i.vars[5]) ^ (~st_i.vars[4] & st_i.vars[6]);
    maj = (st_i.vars[0] & st_i.vars[1]) ^ (st_i.vars[0] & st_i.vars[2]) ^
          (st_i.vars[1] & st_i.vars[2]);
    t1  = st_i.vars[7] + fsb_pkg::bsig1(st_i.vars[4]) + ch + fsb_pkg::SHA_K[6'(STEP)] + wcur;
    t2  = fsb_pkg::bsig0(st_i.vars[0]) + maj;

    st_nxt         = st_i;
    st_nxt.vars[0] = t1 + t2;
    st_nxt.vars[1] = st_i.vars[0];
    st_nxt.vars[2] = st_i.vars[1];
    st_nxt.vars[3] = st_i.vars[2];
    st_nxt.vars[4] = st_i.vars[3] + t1;
    st_nxt.vars[5] = st_i.vars[4];
    st_nxt.vars[6] = st_i.vars[5];
    st_nxt.vars[7] = st_i.vars[6];
    for (int j = 0; j < 15; j++) begin
      st_nxt.win[j] = st_i.win[j + 1];
    end
    st_nxt.win[15] = wcur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (en) begin
      st_r.valid <= st_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r.lh   <= st_nxt.lh;
      st_r.rh   <= st_nxt.rh;
      st_r.vars <= st_nxt.vars;
      st_r.win  <= st_nxt.win;
    end
  end

  assign st_o = st_r;

endmodule

@@ bench/fsb_decrypt_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Feistel SHA-256 block decrypt checker
// Watches the key write port and both block channels, keeps its own key copy,
// computes the plaintext of every accepted request and compares it word by
// word with the plaintext stream in order.
// ----------------------------------------------------------------------------
module fsb_decrypt_checker #(
  parameter int ROUND_COUNT = 5
) (
  input  logic  clk,
  input  logic  rst_n,
  fsb_blk_if    blk,
  fsb_plain_if  plain,
  fsb_cfg_if    cfg,
  output int    fail_count,
  output int    pending_plain,
  output int    blocks_seen
);

  typedef logic [7:0][63:0] block_words_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] DIGEST_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [63:0]  key_low;
  logic [15:0]  key_high;
  block_words_t plain_queue[$];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // hash of the right half, a key segment and zero padding (42-byte message)
  function automatic logic [255:0] round_digest(input logic [255:0] rh,
                                                input logic [15:0] seg);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    logic [255:0] dig;
    for (int i = 0; i < 16; i++) w[i] = '0;
    for (int i = 0; i < 8; i++) w[i] = rh[255 - 32*i -: 32];
    w[8]  = {seg, 16'h0000};
    w[10] = 32'h0000_8000;
    w[15] = 32'd336;
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = DIGEST_IV[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) dig[255 - 32*i -: 32] = DIGEST_IV[i] + v[i];
    return dig;
  endfunction

  function automatic block_words_t decrypt_block(input block_words_t ct,
                                                 input logic [79:0] key);
    logic [255:0] lh, rh, nr;
    block_words_t pt;
    int seg;
    rh = {ct[0], ct[1], ct[2], ct[3]};
    lh = {ct[4], ct[5], ct[6], ct[7]};
    for (int k = 0; k < ROUND_COUNT; k++) begin
      seg = ROUND_COUNT - 1 - k;
      nr = lh ^ round_digest(rh, key[79 - 16*seg -: 16]);
      lh = rh;
      rh = nr;
    end
    {pt[0], pt[1], pt[2], pt[3]} = rh;
    {pt[4], pt[5], pt[6], pt[7]} = lh;
    return pt;
  endfunction

  assign pending_plain = plain_queue.size();

  always @(posedge clk) begin
    block_words_t ct, got, want;
    if (!rst_n) begin
      key_low <= '0;
      key_high <= '0;
      plain_queue.delete();
      fail_count <= 0;
      blocks_seen <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == fsb_pkg::REG_KEY_LOW) key_low <= cfg.data;
        else if (cfg.index == fsb_pkg::REG_KEY_HIGH) key_high <= cfg.data[15:0];
      end
      if (blk.valid && blk.ready) begin
        ct = {blk.block_word_7, blk.block_word_6, blk.block_word_5, blk.block_word_4,
              blk.block_word_3, blk.block_word_2, blk.block_word_1, blk.block_word_0};
        plain_queue.push_back(decrypt_block(ct, {key_low, key_high}));
        blocks_seen <= blocks_seen + 1;
      end
      if (plain.valid && plain.ready) begin
        got = {plain.plain_word_7, plain.plain_word_6, plain.plain_word_5,
               plain.plain_word_4, plain.plain_word_3, plain.plain_word_2,
               plain.plain_word_1, plain.plain_word_0};
        if (plain_queue.size() == 0) begin
          if (fail_count < 10) $display("%0t: plaintext with no request waiting", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          want = plain_queue.pop_front();
          if (got !== want) begin
            for (int i = 0; i < 8; i++)
              if (got[i] !== want[i] && fail_count < 10)
                $display("%0t: plain_word_%0d expected %h got %h",
                         $realtime, i, want[i], got[i]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Feistel SHA-256 block decrypt testbench
// Drives key writes and ciphertext requests with random gaps and output
// stalls, including a long output hold and a full drain, across several key
// settings; the checker predicts and compares every plaintext.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LATENCY = 5 * 65;
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_plain, blocks_seen;
  int   cycle_count = 0;
  bit   idle_on = 1'b1;
  bit   hold_req = 1'b0;
  bit   hold_seen = 1'b0;
  int   hold_cnt = 0;
  int   stall_cnt = 0;

  fsb_blk_if   in_blk();
  fsb_plain_if out_plain();
  fsb_cfg_if   cfg_wr();

  feistel_sha256_block_decrypt DUT (
    .clk(clk), .rst_n(rst_n), .in_blk(in_blk), .out_plain(out_plain), .cfg_wr(cfg_wr)
  );

  fsb_decrypt_checker checker_i (
    .clk(clk), .rst_n(rst_n), .blk(in_blk), .plain(out_plain), .cfg(cfg_wr),
    .fail_count(fail_count), .pending_plain(pending_plain), .blocks_seen(blocks_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // output side: long hold on request, else random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_plain.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= 1500;
      out_plain.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_plain.ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_plain.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_cnt <= $urandom_range(0, 8);
      out_plain.ready <= 1'b0;
    end else begin
      out_plain.ready <= 1'b1;
    end
  end

  task automatic send_block(input logic [7:0][63:0] w);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_blk.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_blk.valid <= 1'b1;
    in_blk.block_word_0 <= w[0]; in_blk.block_word_1 <= w[1];
    in_blk.block_word_2 <= w[2]; in_blk.block_word_3 <= w[3];
    in_blk.block_word_4 <= w[4]; in_blk.block_word_5 <= w[5];
    in_blk.block_word_6 <= w[6]; in_blk.block_word_7 <= w[7];
    do @(posedge clk); while (!(in_blk.valid && in_blk.ready));
  endtask

  task automatic drain_pipe();
    in_blk.valid <= 1'b0;
    @(posedge clk);
    while (pending_plain != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_key(input logic index, input logic [63:0] data);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= index;
    cfg_wr.data <= data;
    do @(posedge clk); while (!(cfg_wr.valid && cfg_wr.ready));
    cfg_wr.valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random(input int count);
    logic [7:0][63:0] w;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 8; i++) w[i] = rand_word();
      send_block(w);
    end
  endtask

  initial begin
    logic [7:0][63:0] w;
    in_blk.valid = 1'b0;
    {in_blk.block_word_0, in_blk.block_word_1, in_blk.block_word_2, in_blk.block_word_3,
     in_blk.block_word_4, in_blk.block_word_5, in_blk.block_word_6,
     in_blk.block_word_7} = '0;
    cfg_wr.valid = 1'b0;
    cfg_wr.index = fsb_pkg::REG_KEY_LOW;
    cfg_wr.data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key: extremes of the block fields
    send_block('0);
    send_block('1);
    send_block({8{64'h5555_5555_5555_5555}});
    send_block({8{64'haaaa_aaaa_aaaa_aaaa}});
    send_block({{4{64'h0}}, {4{64'hffff_ffff_ffff_ffff}}});
    send_block({{4{64'hffff_ffff_ffff_ffff}}, {4{64'h0}}});
    for (int i = 0; i < 8; i++) begin
      w = '0;
      w[i] = 64'h8000_0000_0000_0001 << (i % 2);
      send_block(w);
    end
    drain_pipe();

    // all-ones key; wide value on the short register
    write_key(fsb_pkg::REG_KEY_LOW, '1);
    write_key(fsb_pkg::REG_KEY_HIGH, '1);
    send_block('0);
    send_block('1);
    send_random(300);
    drain_pipe();
    write_key(fsb_pkg::REG_KEY_HIGH, 64'hdead_beef_0000_a5c3);
    write_key(fsb_pkg::REG_KEY_LOW, 64'h0123_4567_89ab_cdef);
    send_random(8);
    drain_pipe();

    // fill the pipe against a long output hold
    write_key(fsb_pkg::REG_KEY_LOW, {$urandom, $urandom});
    hold_req = ~hold_req;
    send_random(500);
    // pause until every plaintext is back, then go on
    drain_pipe();
    send_random(300);
    drain_pipe();

    write_key(fsb_pkg::REG_KEY_LOW, 64'h0000_0000_0000_0001);
    write_key(fsb_pkg::REG_KEY_HIGH, 64'h0000_0000_0000_8000);
    send_random(250);
    drain_pipe();

    write_key(fsb_pkg::REG_KEY_LOW, {$urandom, $urandom});
    write_key(fsb_pkg::REG_KEY_HIGH, {$urandom, $urandom});
    send_random(300);
    drain_pipe();

    // back-to-back tail
    write_key(fsb_pkg::REG_KEY_LOW, '0);
    write_key(fsb_pkg::REG_KEY_HIGH, '0);
    idle_on = 1'b0;
    send_random(270);
    drain_pipe();

    $display("Covered %0d ciphertext blocks over seven key settings,", blocks_seen);
    $display("with gaps, output stalls, a long output hold and full drains.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/fsb_pkg.sv
rtl/core/fsb_blk_if.sv
rtl/core/fsb_plain_if.sv
rtl/core/fsb_cfg_if.sv
rtl/core/fsb_sha_step.sv
rtl/core/feistel_sha256_block_decrypt.sv
bench/fsb_decrypt_checker.sv
bench/testbench.sv
